// ===== hdl/co2poll_pkg.sv =====
// Package for the CO2 sensor poller: item codes, result record, request frame table.
// Used by every file in hdl; depends on nothing.
package co2poll_pkg;

    localparam int unsigned POLL_W    = 20;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned IDLE_W    = 21;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [IDLE_W-1:0] IDLE_MAX   = {IDLE_W{1'b1}};
    localparam logic [TMO_W-1:0]  WAIT_MAX   = {TMO_W{1'b1}};
    localparam logic [3:0]        FRAME_LEN  = 4'd9;
    localparam logic [3:0]        FRAME_LAST = 4'd8;

    localparam logic [7:0] HDR_START = 8'hFF;
    localparam logic [7:0] HDR_CMD   = 8'h86;

    localparam logic [POLL_W-1:0] POLL_RESET = 20'd2000;
    localparam logic [TMO_W-1:0]  TMO_RESET  = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 1'b1;

    // Input item kinds; code 3 has no meaning and is ignored.
    localparam logic [1:0] IN_TICK = 2'd0;
    localparam logic [1:0] IN_BYTE = 2'd1;
    localparam logic [1:0] IN_READ = 2'd2;

    typedef enum logic [1:0] {
        RES_TX     = 2'd0,
        RES_ACCEPT = 2'd1,
        RES_REJECT = 2'd2,
        RES_READ   = 2'd3
    } t_res_kind;

    typedef struct packed {
        t_res_kind   kind;
        logic [7:0]  tx;
        logic [15:0] ppm;
        logic        fresh;
        logic        error;
        logic        last;
    } t_res;

    // Stored status, used to fill the request bytes after the first.
    typedef struct packed {
        logic [15:0] ppm;
        logic        fresh;
        logic        error;
    } t_status;

    // Read request sent to the sensor: FF 01 86 00 00 00 00 00 79.
    function automatic logic [7:0] req_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hFF;
            4'd1:    b = 8'h01;
            4'd2:    b = 8'h86;
            4'd8:    b = 8'h79;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/co2poll_if.sv =====
// Handshake channels of the CO2 sensor poller: input items, result items, config writes.
// Depends on co2poll_pkg for field widths.
interface co2poll_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface co2poll_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic [15:0] co2_ppm;
    logic        fresh;
    logic        error_flag;
    logic        last;
    modport source (output valid, output result_kind, output tx_byte, output co2_ppm,
                    output fresh, output error_flag, output last, input ready);
    modport sink   (input valid, input result_kind, input tx_byte, input co2_ppm,
                    input fresh, input error_flag, input last, output ready);
endinterface

interface co2poll_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [co2poll_pkg::CFG_IDX_W-1:0]   index;
    logic [co2poll_pkg::POLL_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/co2poll_core.sv =====
// Poll state, reply collection and frame check for the CO2 sensor poller.
// Depends on co2poll_pkg; feeds co2poll_out with at most one result record per accepted item.
module co2poll_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  logic [1:0]                          i_kind,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_cfg_we,
    input  logic [co2poll_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [co2poll_pkg::POLL_W-1:0]      i_cfg_data,
    output logic                                o_res_valid,
    output logic                                o_burst,
    output co2poll_pkg::t_res                   o_res,
    output co2poll_pkg::t_status                o_status
);

    logic [co2poll_pkg::POLL_W-1:0] r_interval;
    logic [co2poll_pkg::TMO_W-1:0]  r_timeout;
    logic                           r_await,  n_await;
    logic [co2poll_pkg::IDLE_W-1:0] r_idle,   n_idle;
    logic [co2poll_pkg::TMO_W-1:0]  r_wait,   n_wait;
    logic [3:0]                     r_pos,    n_pos;
    logic [7:0]                     r_sum,    n_sum;
    logic [7:0]                     r_b0, r_b1, r_b2, r_b3, r_b8;
    logic [7:0]                     n_b0, n_b1, n_b2, n_b3, n_b8;
    logic [15:0]                    r_ppm,    n_ppm;
    logic                           r_fresh,  n_fresh;
    logic                           r_err,    n_err;

    logic [co2poll_pkg::IDLE_W-1:0] idle_inc;
    logic [co2poll_pkg::TMO_W-1:0]  wait_inc;
    logic                           poll_due;
    logic                           timed_out;
    logic                           byte_take;
    logic                           byte_final;
    logic [7:0]                     b8_eval;
    logic                           frame_ok;
    logic                           evaluate;

    assign idle_inc  = (r_idle == co2poll_pkg::IDLE_MAX) ? r_idle
                     : r_idle + co2poll_pkg::IDLE_W'(1);
    assign wait_inc  = (r_wait == co2poll_pkg::WAIT_MAX) ? r_wait
                     : r_wait + co2poll_pkg::TMO_W'(1);
    assign poll_due  = idle_inc > {1'b0, r_interval};
    assign timed_out = wait_inc >= r_timeout;
    assign byte_take = r_await && (r_pos < co2poll_pkg::FRAME_LEN);
    assign byte_final = byte_take && (r_pos == co2poll_pkg::FRAME_LAST);

    // On the ninth byte the checksum byte is the incoming one.
    assign b8_eval  = (i_kind == co2poll_pkg::IN_BYTE && byte_final) ? i_rx_byte : r_b8;
    assign frame_ok = (r_b0 == co2poll_pkg::HDR_START) && (r_b1 == co2poll_pkg::HDR_CMD)
                   && (b8_eval == 8'(8'd0 - r_sum));

    always_comb begin
        n_await = r_await;
        n_idle  = r_idle;
        n_wait  = r_wait;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_b0    = r_b0;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_b3    = r_b3;
        n_b8    = r_b8;
        n_ppm   = r_ppm;
        n_fresh = r_fresh;
        n_err   = r_err;
        evaluate    = 1'b0;
        o_res_valid = 1'b0;
        o_burst     = 1'b0;
        o_res.kind  = co2poll_pkg::RES_TX;
        o_res.tx    = 8'h00;
        o_res.last  = 1'b1;

        case (i_kind)
            co2poll_pkg::IN_TICK: begin
                if (!r_await) begin
                    if (poll_due) begin
                        // Launch the request burst and clear the reply store.
                        o_res_valid = 1'b1;
                        o_burst     = 1'b1;
                        o_res.tx    = co2poll_pkg::req_byte(4'd0);
                        o_res.last  = 1'b0;
                        n_await = 1'b1;
                        n_idle  = '0;
                        n_wait  = '0;
                        n_pos   = '0;
                        n_sum   = '0;
                        n_b0    = '0;
                        n_b1    = '0;
                        n_b2    = '0;
                        n_b3    = '0;
                        n_b8    = '0;
                    end else begin
                        n_idle = idle_inc;
                    end
                end else begin
                    n_wait   = wait_inc;
                    evaluate = timed_out;
                end
            end
            co2poll_pkg::IN_BYTE: begin
                if (byte_take) begin
                    case (r_pos)
                        4'd0:    n_b0 = i_rx_byte;
                        4'd1:    n_b1 = i_rx_byte;
                        4'd2:    n_b2 = i_rx_byte;
                        4'd3:    n_b3 = i_rx_byte;
                        4'd8:    n_b8 = i_rx_byte;
                        default: n_b0 = r_b0;
                    endcase
                    if (r_pos >= 4'd1 && r_pos <= 4'd7) begin
                        n_sum = r_sum + i_rx_byte;
                    end
                    n_pos    = r_pos + 4'd1;
                    evaluate = byte_final;
                end
            end
            co2poll_pkg::IN_READ: begin
                o_res_valid = 1'b1;
                o_res.kind  = co2poll_pkg::RES_READ;
                n_fresh     = 1'b0;
            end
            default: begin
                n_await = r_await;
            end
        endcase

        if (evaluate) begin
            if (frame_ok) begin
                n_ppm   = {r_b2, r_b3};
                n_fresh = 1'b1;
                n_err   = 1'b0;
            end else begin
                n_err = 1'b1;
            end
            n_await     = 1'b0;
            n_idle      = '0;
            n_wait      = '0;
            o_res_valid = 1'b1;
            o_res.kind  = frame_ok ? co2poll_pkg::RES_ACCEPT : co2poll_pkg::RES_REJECT;
        end

        o_res.ppm   = n_ppm;
        o_res.error = n_err;
        // A reading reply shows the fresh mark before it is cleared.
        o_res.fresh = (i_kind == co2poll_pkg::IN_READ) ? r_fresh : n_fresh;
    end

    assign o_status.ppm   = r_ppm;
    assign o_status.fresh = r_fresh;
    assign o_status.error = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= co2poll_pkg::POLL_RESET;
            r_timeout  <= co2poll_pkg::TMO_RESET;
            r_await    <= 1'b0;
            r_idle     <= '0;
            r_wait     <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_ppm      <= '0;
            r_fresh    <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == co2poll_pkg::CFG_POLL_INTERVAL) begin
                r_interval <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == co2poll_pkg::CFG_REPLY_TIMEOUT) begin
                r_timeout <= i_cfg_data[co2poll_pkg::TMO_W-1:0];
            end
            if (i_fire) begin
                r_await <= n_await;
                r_idle  <= n_idle;
                r_wait  <= n_wait;
                r_pos   <= n_pos;
                r_sum   <= n_sum;
                r_ppm   <= n_ppm;
                r_fresh <= n_fresh;
                r_err   <= n_err;
            end
        end
    end

    // Reply bytes are cleared on every request before they are read.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_b0 <= n_b0;
            r_b1 <= n_b1;
            r_b2 <= n_b2;
            r_b3 <= n_b3;
            r_b8 <= n_b8;
        end
    end

endmodule

// ===== hdl/co2poll_out.sv =====
// Result register and request-burst sequencer for the CO2 sensor poller.
// Depends on co2poll_pkg; takes result records from co2poll_core.
module co2poll_out (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic                    i_burst,
    input  co2poll_pkg::t_res       i_res,
    input  co2poll_pkg::t_status    i_status,
    input  logic                    i_take_ready,
    output logic                    o_in_ready,
    output logic                    o_valid,
    output co2poll_pkg::t_res       o_res
);

    logic                   r_valid;
    co2poll_pkg::t_res      r_res;
    logic                   r_burst_on;
    logic [3:0]             r_burst_idx;
    logic                   take;
    logic                   free;
    co2poll_pkg::t_res      burst_res;

    assign take       = r_valid && i_take_ready;
    assign free       = !r_valid || take;
    // Hold the input side while request bytes are still to be sent.
    assign o_in_ready = free && !r_burst_on;

    always_comb begin
        burst_res.kind  = co2poll_pkg::RES_TX;
        burst_res.tx    = co2poll_pkg::req_byte(r_burst_idx);
        burst_res.ppm   = i_status.ppm;
        burst_res.fresh = i_status.fresh;
        burst_res.error = i_status.error;
        burst_res.last  = (r_burst_idx == co2poll_pkg::FRAME_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_burst_on  <= 1'b0;
            r_burst_idx <= '0;
        end else if (r_burst_on && free) begin
            r_valid     <= 1'b1;
            r_res       <= burst_res;
            r_burst_idx <= r_burst_idx + 4'd1;
            if (r_burst_idx == co2poll_pkg::FRAME_LAST) begin
                r_burst_on <= 1'b0;
            end
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_res   <= i_res;
            if (i_burst) begin
                r_burst_on  <= 1'b1;
                r_burst_idx <= 4'd1;
            end
        end else if (take) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hdl/co2_sensor_poll_and_frame_check.sv =====
// Top level of the CO2 sensor poller: polls the sensor and checks its reply frames.
// Depends on co2poll_pkg, co2poll_if, co2poll_core and co2poll_out.
//
// Takes one item per clock while input ready is high. A tick that starts a
// poll yields nine request bytes that leave the result register one per
// cycle while the result side takes them; input ready stays low until the
// last of them is loaded by the burst sequencer that feeds the register.
// Every other item gives at most one result, which is held in the result
// register, and the next item is accepted in the same cycle as
// long as that register is free or being taken. Configuration writes are
// always ready and take effect on the next item.
module co2_sensor_poll_and_frame_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    co2poll_in_if.sink           i_req,
    co2poll_out_if.source        o_res,
    co2poll_cfg_if.sink          i_cfg
);

    logic                   in_ready;
    logic                   in_fire;
    logic                   res_valid;
    logic                   res_burst;
    co2poll_pkg::t_res      core_res;
    co2poll_pkg::t_status   status;
    co2poll_pkg::t_res      out_res;
    logic                   out_valid;

    assign i_req.ready = in_ready;
    assign in_fire     = i_req.valid && in_ready;
    assign i_cfg.ready = 1'b1;

    co2poll_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_kind      (i_req.kind),
        .i_rx_byte   (i_req.rx_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_res_valid (res_valid),
        .o_burst     (res_burst),
        .o_res       (core_res),
        .o_status    (status)
    );

    co2poll_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_fire && res_valid),
        .i_burst      (res_burst),
        .i_res        (core_res),
        .i_status     (status),
        .i_take_ready (o_res.ready),
        .o_in_ready   (in_ready),
        .o_valid      (out_valid),
        .o_res        (out_res)
    );

    assign o_res.valid       = out_valid;
    assign o_res.result_kind = out_res.kind;
    assign o_res.tx_byte     = out_res.tx;
    assign o_res.co2_ppm     = out_res.ppm;
    assign o_res.fresh       = out_res.fresh;
    assign o_res.error_flag  = out_res.error;
    assign o_res.last        = out_res.last;

endmodule

// ===== hdl/co2poll_checker.sv =====
// Port-level checks for the CO2 sensor poller, bound to the top level.
// Depends on co2poll_pkg for result codes.
module co2poll_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_ready,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_result_kind,
    input  logic [7:0]  i_tx_byte,
    input  logic [15:0] i_co2_ppm,
    input  logic        i_fresh,
    input  logic        i_error_flag,
    input  logic        i_last
);

    // A stalled result holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_result_kind)
            && $stable(i_tx_byte) && $stable(i_co2_ppm) && $stable(i_fresh)
            && $stable(i_error_flag) && $stable(i_last))
        else $error("stalled result changed");

    // Request bytes follow one another without a gap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_ready && !i_last
            && i_result_kind == co2poll_pkg::RES_TX
            |=> i_res_valid && i_result_kind == co2poll_pkg::RES_TX)
        else $error("request burst broken");

    // No input item is taken while a request burst is still going out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_last |-> !i_req_ready)
        else $error("input accepted during request burst");

    // Single results end their item and carry no transmit byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_result_kind != co2poll_pkg::RES_TX |-> i_last && i_tx_byte == 8'h00)
        else $error("single result malformed");

    // The error flag matches the frame verdict.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_result_kind == co2poll_pkg::RES_ACCEPT
            || i_result_kind == co2poll_pkg::RES_REJECT)
            |-> i_error_flag == (i_result_kind == co2poll_pkg::RES_REJECT))
        else $error("error flag disagrees with frame verdict");

endmodule

bind co2_sensor_poll_and_frame_check co2poll_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_ready   (i_req.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_result_kind (o_res.result_kind),
    .i_tx_byte     (o_res.tx_byte),
    .i_co2_ppm     (o_res.co2_ppm),
    .i_fresh       (o_res.fresh),
    .i_error_flag  (o_res.error_flag),
    .i_last        (o_res.last)
);

// ===== dv/co2_sensor_poll_and_frame_check_tb.sv =====
// Self-checking testbench for the CO2 sensor poller: random and directed ticks, bytes, reads.
// Depends on co2poll_pkg, the co2poll interfaces and co2_sensor_poll_and_frame_check.
`timescale 1ns / 1ps

module co2_sensor_poll_and_frame_check_tb;

    localparam logic [1:0]                    IN_NONE      = 2'd3;
    localparam logic [co2poll_pkg::POLL_W-1:0] INTERVAL_MAX = {co2poll_pkg::POLL_W{1'b1}};
    localparam logic [co2poll_pkg::TMO_W-1:0]  TIMEOUT_MAX  = {co2poll_pkg::TMO_W{1'b1}};
    localparam int                RANDOM_ITEMS  = 300;
    localparam int                PHASE_ITEMS   = 60;
    localparam int                HOLD_CYCLES   = 300;
    localparam logic [0:8][7:0]   POLL_CMD      = {8'hFF, 8'h01, 8'h86, 8'h00, 8'h00,
                                                   8'h00, 8'h00, 8'h00, 8'h79};

    typedef enum {FLAW_NONE, FLAW_START, FLAW_CMD, FLAW_SUM} t_flaw;
    typedef enum {SINK_ALWAYS, SINK_MOSTLY, SINK_RARELY, SINK_EVERY_THIRD} t_sink_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx;
    } t_item;

    typedef struct {
        logic            waiting;
        logic [20:0]     idle_cnt;
        logic [15:0]     wait_cnt;
        logic [3:0]      pos;
        logic [7:0]      sum;
        logic [0:8][7:0] frame;
        logic [15:0]     ppm;
        logic            fresh;
        logic            err;
        logic [19:0]     interval;
        logic [15:0]     timeout;
    } t_poller;

    logic i_clk = 1'b0;
    logic i_rst_n;

    co2poll_in_if  req_if ();
    co2poll_out_if res_if ();
    co2poll_cfg_if cfg_if ();

    co2_sensor_poll_and_frame_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_poller           chk_m;
    t_poller           gen_m;
    t_item             stim_q[$];
    co2poll_pkg::t_res due_results[$];
    t_item             drv_item;
    co2poll_pkg::t_res want;
    int         queued_cnt = 0;
    int         taken_cnt = 0;
    int         live_cnt = 0;
    int         fail_cnt = 0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         hold_token = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         mode_left = 0;
    int         sink_cycle = 0;
    t_sink_mode sink_mode = SINK_ALWAYS;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_poller poller_reset();
        t_poller m;
        m.waiting  = 1'b0;
        m.idle_cnt = '0;
        m.wait_cnt = '0;
        m.pos      = '0;
        m.sum      = '0;
        m.frame    = '0;
        m.ppm      = '0;
        m.fresh    = 1'b0;
        m.err      = 1'b0;
        m.interval = co2poll_pkg::POLL_RESET;
        m.timeout  = co2poll_pkg::TMO_RESET;
        return m;
    endfunction

    function automatic void poller_config(inout t_poller m,
                                          input logic [co2poll_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [co2poll_pkg::POLL_W-1:0] data);
        if (idx == co2poll_pkg::CFG_POLL_INTERVAL) begin
            m.interval = data;
        end else begin
            m.timeout = data[co2poll_pkg::TMO_W-1:0];
        end
    endfunction

    function automatic co2poll_pkg::t_res make_res(t_poller m, co2poll_pkg::t_res_kind k,
                                                   logic [7:0] tx, logic fr, logic lst);
        co2poll_pkg::t_res r;
        r.kind  = k;
        r.tx    = tx;
        r.ppm   = m.ppm;
        r.fresh = fr;
        r.error = m.err;
        r.last  = lst;
        return r;
    endfunction

    function automatic logic [7:0] frame_cks(logic [0:8][7:0] f);
        logic [7:0] s;
        s = '0;
        for (int i = 1; i <= 7; i++) s = s + f[i];
        return 8'h00 - s;
    endfunction

    function automatic void frame_close(inout t_poller m, inout co2poll_pkg::t_res q[$]);
        logic ok;
        ok = m.frame[0] == co2poll_pkg::HDR_START && m.frame[1] == co2poll_pkg::HDR_CMD
            && m.frame[8] == 8'h00 - m.sum;
        if (ok) begin
            m.ppm   = {m.frame[2], m.frame[3]};
            m.fresh = 1'b1;
            m.err   = 1'b0;
        end else begin
            m.err = 1'b1;
        end
        m.waiting  = 1'b0;
        m.idle_cnt = '0;
        m.wait_cnt = '0;
        q.push_back(make_res(m, ok ? co2poll_pkg::RES_ACCEPT : co2poll_pkg::RES_REJECT,
                             8'h00, m.fresh, 1'b1));
    endfunction

    function automatic void poller_step(inout t_poller m, input logic [1:0] kind,
                                        input logic [7:0] b,
                                        inout co2poll_pkg::t_res q[$]);
        case (kind)
            co2poll_pkg::IN_TICK: begin
                if (!m.waiting) begin
                    if (m.idle_cnt != co2poll_pkg::IDLE_MAX) m.idle_cnt++;
                    if (m.idle_cnt > {1'b0, m.interval}) begin
                        for (int i = 0; i < 9; i++)
                            q.push_back(make_res(m, co2poll_pkg::RES_TX, POLL_CMD[i],
                                                 m.fresh, i == 8));
                        m.waiting  = 1'b1;
                        m.idle_cnt = '0;
                        m.wait_cnt = '0;
                        m.pos      = '0;
                        m.sum      = '0;
                        m.frame    = '0;
                    end
                end else begin
                    if (m.wait_cnt != co2poll_pkg::WAIT_MAX) m.wait_cnt++;
                    if (m.wait_cnt >= m.timeout) frame_close(m, q);
                end
            end
            co2poll_pkg::IN_BYTE: begin
                if (m.waiting && m.pos < co2poll_pkg::FRAME_LEN) begin
                    m.frame[m.pos] = b;
                    if (m.pos >= 1 && m.pos <= 7) m.sum = m.sum + b;
                    m.pos++;
                    if (m.pos == co2poll_pkg::FRAME_LEN) frame_close(m, q);
                end
            end
            co2poll_pkg::IN_READ: begin
                q.push_back(make_res(m, co2poll_pkg::RES_READ, 8'h00, m.fresh, 1'b1));
                m.fresh = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic push_item(input logic [1:0] k, input logic [7:0] b);
        co2poll_pkg::t_res scratch[$];
        if (k != IN_NONE && !(k == co2poll_pkg::IN_BYTE && !gen_m.waiting)) live_cnt++;
        stim_q.push_back('{k, b});
        queued_cnt++;
        poller_step(gen_m, k, b, scratch);
    endtask

    // Feed a reply frame, sprinkling reads, unused codes and (with a long timeout) ticks.
    task automatic push_frame(input logic [0:8][7:0] f);
        int r;
        for (int i = 0; i < 9; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_item(co2poll_pkg::IN_READ, 8'($urandom));
            end else if (r < 12) begin
                push_item(IN_NONE, 8'($urandom));
            end else if (r < 20 && gen_m.timeout > 20) begin
                push_item(co2poll_pkg::IN_TICK, 8'($urandom));
            end
            push_item(co2poll_pkg::IN_BYTE, f[i]);
        end
    endtask

    task automatic push_reply(input t_flaw flaw);
        logic [0:8][7:0] f;
        f[0] = co2poll_pkg::HDR_START;
        f[1] = co2poll_pkg::HDR_CMD;
        for (int i = 2; i <= 7; i++) f[i] = 8'($urandom);
        f[8] = frame_cks(f);
        case (flaw)
            FLAW_START: f[0] = f[0] ^ 8'($urandom_range(1, 255));
            FLAW_CMD:   f[1] = f[1] ^ 8'($urandom_range(1, 255));
            FLAW_SUM:   f[8] = f[8] ^ 8'($urandom_range(1, 255));
            default: begin
            end
        endcase
        push_frame(f);
    endtask

    task automatic push_partial();
        int n;
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
            push_item(co2poll_pkg::IN_BYTE, i == 0 ? co2poll_pkg::HDR_START : 8'($urandom));
        while (gen_m.waiting) push_item(co2poll_pkg::IN_TICK, 8'($urandom));
    endtask

    task automatic wait_drained();
        while (stim_q.size() != 0 || taken_cnt != queued_cnt || due_results.size() != 0)
            @(posedge i_clk);
        // the block may still be working on an item that gave no result
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [co2poll_pkg::CFG_IDX_W-1:0] idx,
                             input logic [co2poll_pkg::POLL_W-1:0] data);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        poller_config(chk_m, idx, data);
        poller_config(gen_m, idx, data);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Driver: bursts of items with random gaps; predict each item as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                poller_step(chk_m, req_if.kind, req_if.rx_byte, due_results);
                taken_cnt++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    drv_item = stim_q.pop_front();
                    req_if.kind    <= drv_item.kind;
                    req_if.rx_byte <= drv_item.rx;
                    req_if.valid   <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: the stall pattern is redrawn at random; a hold request
    // drops ready for a long stretch.
    always @(posedge i_clk) begin
        sink_cycle++;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = t_sink_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(8, 80);
                end else begin
                    mode_left--;
                end
                case (sink_mode)
                    SINK_ALWAYS:  res_if.ready <= 1'b1;
                    SINK_MOSTLY:  res_if.ready <= $urandom_range(0, 3) != 0;
                    SINK_RARELY:  res_if.ready <= $urandom_range(0, 3) == 0;
                    default:      res_if.ready <= sink_cycle % 3 == 0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result item: result_kind %0d", res_if.result_kind);
                fail_cnt++;
            end else begin
                want = due_results.pop_front();
                check_field("result_kind", want.kind, res_if.result_kind);
                check_field("tx_byte", want.tx, res_if.tx_byte);
                check_field("co2_ppm", want.ppm, res_if.co2_ppm);
                check_field("fresh", want.fresh, res_if.fresh);
                check_field("error_flag", want.error, res_if.error_flag);
                check_field("last", want.last, res_if.last);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("co2_sensor_poll_and_frame_check_tb failed");
        $finish;
    end

    initial begin
        logic [0:8][7:0]                f;
        logic [co2poll_pkg::POLL_W-1:0] ivl;
        logic [co2poll_pkg::TMO_W-1:0]  tmo;
        int                             rand_start;
        int                             phase_end;
        int                             p;
        int                             r;

        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.kind    = co2poll_pkg::IN_TICK;
        req_if.rx_byte = 8'h00;
        res_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = co2poll_pkg::CFG_POLL_INTERVAL;
        cfg_if.data    = '0;
        chk_m = poller_reset();
        gen_m = poller_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state: a dropped byte, an unused code, ticks short of the interval, a read.
        push_item(co2poll_pkg::IN_BYTE, 8'hA5);
        push_item(IN_NONE, 8'h5A);
        repeat (4) push_item(co2poll_pkg::IN_TICK, 8'($urandom));
        push_item(co2poll_pkg::IN_READ, 8'($urandom));
        wait_drained();

        // Directed: dropped items, request burst, full frame, reads, timeouts.
        write_reg(co2poll_pkg::CFG_POLL_INTERVAL, 20'd1);
        write_reg(co2poll_pkg::CFG_REPLY_TIMEOUT, 20'd2);
        push_item(IN_NONE, 8'hFF);
        push_item(co2poll_pkg::IN_BYTE, 8'h00);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        push_item(co2poll_pkg::IN_TICK, 8'hFF);
        push_item(co2poll_pkg::IN_READ, 8'h00);
        f = {co2poll_pkg::HDR_START, co2poll_pkg::HDR_CMD, 8'hFF, 8'hFF, 8'h00, 8'h00,
             8'h00, 8'h00, 8'h00};
        f[8] = frame_cks(f);
        for (int i = 0; i < 9; i++) push_item(co2poll_pkg::IN_BYTE, f[i]);
        push_item(co2poll_pkg::IN_READ, 8'hFF);
        push_item(co2poll_pkg::IN_READ, 8'h00);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        push_item(co2poll_pkg::IN_BYTE, 8'hFF);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        wait_drained();
        write_reg(co2poll_pkg::CFG_REPLY_TIMEOUT, 20'd0);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        push_item(co2poll_pkg::IN_TICK, 8'h00);
        push_item(co2poll_pkg::IN_READ, 8'h00);
        wait_drained();

        rand_start = live_cnt;
        p = 0;
        while (live_cnt - rand_start < RANDOM_ITEMS) begin
            case (p)
                0: begin
                    ivl = INTERVAL_MAX;
                    tmo = TIMEOUT_MAX;
                end
                1: begin
                    ivl = '0;
                    tmo = '0;
                end
                2: begin
                    ivl = '0;
                    tmo = 16'd1;
                end
                3: begin
                    ivl = 20'($urandom_range(0, 3));
                    tmo = TIMEOUT_MAX;
                end
                default: begin
                    r = $urandom_range(0, 5);
                    ivl = r == 0 ? INTERVAL_MAX : 20'($urandom_range(0, 10));
                    r = $urandom_range(0, 5);
                    tmo = r == 0 ? '0 : r == 1 ? TIMEOUT_MAX : 16'($urandom_range(1, 12));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(co2poll_pkg::CFG_POLL_INTERVAL, ivl);
                write_reg(co2poll_pkg::CFG_REPLY_TIMEOUT, 20'(tmo));
            end else begin
                write_reg(co2poll_pkg::CFG_REPLY_TIMEOUT, 20'(tmo));
                write_reg(co2poll_pkg::CFG_POLL_INTERVAL, ivl);
            end
            // stall the result side while items keep coming, to back up the input
            if (p == 2) hold_token++;
            phase_end = live_cnt + PHASE_ITEMS;
            while (live_cnt < phase_end) begin
                r = $urandom_range(0, 99);
                if (gen_m.interval > 20'd1000 && !gen_m.waiting) begin
                    push_item(2'($urandom_range(0, 3)), 8'($urandom));
                end else if (!gen_m.waiting) begin
                    if (r < 70) begin
                        push_item(co2poll_pkg::IN_TICK, 8'($urandom));
                    end else if (r < 85) begin
                        push_item(co2poll_pkg::IN_READ, 8'($urandom));
                    end else if (r < 93) begin
                        push_item(co2poll_pkg::IN_BYTE, 8'($urandom));
                    end else begin
                        push_item(IN_NONE, 8'($urandom));
                    end
                end else if (r < 50) begin
                    push_reply(FLAW_NONE);
                end else if (r < 75 || gen_m.timeout > 16'd12) begin
                    push_reply(t_flaw'($urandom_range(1, 3)));
                end else begin
                    push_partial();
                end
            end
            wait_drained();
            p++;
        end

        repeat (16) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("co2_sensor_poll_and_frame_check_tb passed");
        end else begin
            $display("co2_sensor_poll_and_frame_check_tb failed");
        end
        $finish;
    end

endmodule
